// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
package lkvc_pkg;

   localparam int DEPTH_DEF       = 16;
   localparam int KEY_WIDTH_DEF   = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   // capacity register and reported entry count are fixed 5-bit fields
   localparam int CAP_W   = 5;
   localparam int COUNT_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // enables from the sequencer to the storage arrays
   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic val_we;
      logic rank_we;
   } mem_ctl_type;

endpackage

// ===== rtl/lkvc_store.sv =====
`timescale 1ns / 1ps
module lkvc_store #(
   parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  lkvc_pkg::mem_ctl_type      mem_ctl,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic [$clog2(DEPTH)-1:0]   kv_waddr,
   input  logic [KEY_WIDTH-1:0]       key_wdata,
   input  logic [VALUE_WIDTH-1:0]     val_wdata,
   input  logic [$clog2(DEPTH)-1:0]   rank_waddr,
   input  logic [$clog2(DEPTH)-1:0]   rank_wdata,
   output logic [KEY_WIDTH-1:0]       key_rd,
   output logic [VALUE_WIDTH-1:0]     val_rd,
   output logic [$clog2(DEPTH)-1:0]   rank_rd
);
   import lkvc_pkg::*;

   localparam int RW = $clog2(DEPTH);

   logic [KEY_WIDTH-1:0]   key_mem  [DEPTH];
   logic [VALUE_WIDTH-1:0] val_mem  [DEPTH];
   logic [RW-1:0]          rank_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_ctl.key_we) begin
         key_mem[kv_waddr] <= key_wdata;
      end
      if (mem_ctl.val_we) begin
         val_mem[kv_waddr] <= val_wdata;
      end
      if (mem_ctl.rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         key_rd  <= key_mem[rd_addr];
         val_rd  <= val_mem[rd_addr];
         rank_rd <= rank_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
module lkvc_ctrl #(
   parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [KEY_WIDTH-1:0]          req_key,
   input  logic [VALUE_WIDTH-1:0]        req_write_value,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [VALUE_WIDTH-1:0]        rsp_read_value,
   output logic [lkvc_pkg::COUNT_W-1:0]  rsp_entry_count,
   output lkvc_pkg::mem_ctl_type         mem_ctl,
   output logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [$clog2(DEPTH)-1:0]      kv_waddr,
   output logic [KEY_WIDTH-1:0]          key_wdata,
   output logic [VALUE_WIDTH-1:0]        val_wdata,
   output logic [$clog2(DEPTH)-1:0]      rank_waddr,
   output logic [$clog2(DEPTH)-1:0]      rank_wdata,
   input  logic [KEY_WIDTH-1:0]          key_rd,
   input  logic [VALUE_WIDTH-1:0]        val_rd,
   input  logic [$clog2(DEPTH)-1:0]      rank_rd
);
   import lkvc_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;
   localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0]    count_ff, count_in;

   logic [AW-1:0]    addr_ff, addr_in;
   logic             done_ff, done_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pidx_ff, pidx_in;

   logic                   op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] wval_ff, wval_in;
   logic [VALUE_WIDTH-1:0] rval_ff, rval_in;

   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [AW-1:0] found_rank_ff, found_rank_in;
   logic          free_ok_ff, free_ok_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          lru_ok_ff, lru_ok_in;
   logic [AW-1:0] lru_idx_ff, lru_idx_in;
   logic [AW-1:0] lru_rank_ff, lru_rank_in;

   logic [AW-1:0] target_ff, target_in;
   logic [AW-1:0] thr_ff, thr_in;
   logic          all_inc_ff, all_inc_in;

   logic [EW-1:0] eff_cap;
   logic          evict;
   logic [AW-1:0] slot_sel;
   logic          last_data;
   logic          cur_valid;
   logic [MW-1:0] count_wide;

   // capacity zero acts as one, capacity above the depth acts as the depth
   always_comb begin
      if (capacity == '0) begin
         eff_cap = EW'(1);
      end else if (EW'(capacity) > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = EW'(capacity);
      end
   end

   assign evict     = EW'(count_ff) >= eff_cap;
   assign slot_sel  = evict ? lru_idx_ff : free_idx_ff;
   assign last_data = pend_ff && (pidx_ff == LAST_ADDR);
   assign cur_valid = valid_ff[pidx_ff];

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      done_in       = done_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      rval_in       = rval_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      lru_ok_in     = lru_ok_ff;
      lru_idx_in    = lru_idx_ff;
      lru_rank_in   = lru_rank_ff;
      target_in     = target_ff;
      thr_in        = thr_ff;
      all_inc_in    = all_inc_ff;
      mem_ctl       = '0;
      rd_addr       = addr_ff;
      kv_waddr      = target_ff;
      key_wdata     = key_ff;
      val_wdata     = wval_ff;
      rank_waddr    = pidx_ff;
      rank_wdata    = '0;

      // one read per cycle over all slots; the read data comes back in the next cycle
      if ((state_ff == ST_SCAN || state_ff == ST_UPDATE) && !done_ff) begin
         mem_ctl.rd_en = 1'b1;
         pend_in       = 1'b1;
         pidx_in       = addr_ff;
         addr_in       = addr_ff + 1'b1;
         if (addr_ff == LAST_ADDR) begin
            done_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_operation;
               key_in     = req_key;
               wval_in    = req_write_value;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               lru_ok_in  = 1'b0;
               addr_in    = '0;
               done_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               if (cur_valid && key_rd == key_ff && !found_ff) begin
                  found_in      = 1'b1;
                  found_idx_in  = pidx_ff;
                  found_rank_in = rank_rd;
                  rval_in       = val_rd;
               end
               if (!cur_valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = pidx_ff;
               end
               if (cur_valid && (!lru_ok_ff || rank_rd > lru_rank_ff)) begin
                  lru_ok_in   = 1'b1;
                  lru_idx_in  = pidx_ff;
                  lru_rank_in = rank_rd;
               end
            end
            if (last_data) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            addr_in = '0;
            done_in = 1'b0;
            if (found_ff) begin
               target_in  = found_idx_ff;
               thr_in     = found_rank_ff;
               all_inc_in = 1'b0;
               kv_waddr   = found_idx_ff;
               if (op_ff == OP_PUT) begin
                  mem_ctl.val_we = 1'b1;
               end
               state_in = ST_UPDATE;
            end else if (op_ff == OP_PUT) begin
               // evicted slot is refilled in place, so the count holds
               target_in          = slot_sel;
               all_inc_in         = 1'b1;
               kv_waddr           = slot_sel;
               mem_ctl.key_we     = 1'b1;
               mem_ctl.val_we     = 1'b1;
               valid_in[slot_sel] = 1'b1;
               if (!evict) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UPDATE: begin
            if (pend_ff) begin
               if (pidx_ff == target_ff) begin
                  mem_ctl.rank_we = 1'b1;
                  rank_wdata      = '0;
               end else if (cur_valid && (all_inc_ff || rank_rd < thr_ff)) begin
                  mem_ctl.rank_we = 1'b1;
                  rank_wdata      = rank_rd + 1'b1;
               end
            end
            if (last_data) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      pidx_ff       <= pidx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      rval_ff       <= rval_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      lru_ok_ff     <= lru_ok_in;
      lru_idx_ff    <= lru_idx_in;
      lru_rank_ff   <= lru_rank_in;
      target_ff     <= target_in;
      thr_ff        <= thr_in;
      all_inc_ff    <= all_inc_in;
   end

   assign count_wide      = MW'(count_ff);
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_hit         = found_ff;
   assign rsp_read_value  = (found_ff && op_ff == OP_GET) ? rval_ff : '0;
   assign rsp_entry_count = count_wide[COUNT_W-1:0];

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// A get miss makes one pass over the key/value/rank memories to search and then responds;
// a hit or a put makes that search pass and then one read-modify-write pass over the rank
// memory, one slot per cycle.
// One request at a time: busy until the response cycle has passed. Reset clears all valid
// bits, the entry count, sets capacity to 16; the response is a one-cycle strobe, never
// stalled.
`timescale 1ns / 1ps
module lru_key_value_cache_unit #(
   parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [KEY_WIDTH-1:0]          req_key,
   input  logic [VALUE_WIDTH-1:0]        req_write_value,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [VALUE_WIDTH-1:0]        rsp_read_value,
   output logic [lkvc_pkg::COUNT_W-1:0]  rsp_entry_count,
   input  logic                          csr_write_enable,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_write_data
);
   import lkvc_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [CAP_W-1:0] cap_ff, cap_in;

   mem_ctl_type            mem_ctl;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          kv_waddr;
   logic [KEY_WIDTH-1:0]   key_wdata;
   logic [VALUE_WIDTH-1:0] val_wdata;
   logic [AW-1:0]          rank_waddr;
   logic [AW-1:0]          rank_wdata;
   logic [KEY_WIDTH-1:0]   key_rd;
   logic [VALUE_WIDTH-1:0] val_rd;
   logic [AW-1:0]          rank_rd;

   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lkvc_ctrl #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .capacity        (cap_ff),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .mem_ctl         (mem_ctl),
      .rd_addr         (rd_addr),
      .kv_waddr        (kv_waddr),
      .key_wdata       (key_wdata),
      .val_wdata       (val_wdata),
      .rank_waddr      (rank_waddr),
      .rank_wdata      (rank_wdata),
      .key_rd          (key_rd),
      .val_rd          (val_rd),
      .rank_rd         (rank_rd)
   );

   lkvc_store #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .rd_addr    (rd_addr),
      .kv_waddr   (kv_waddr),
      .key_wdata  (key_wdata),
      .val_wdata  (val_wdata),
      .rank_waddr (rank_waddr),
      .rank_wdata (rank_wdata),
      .key_rd     (key_rd),
      .val_rd     (val_rd),
      .rank_rd    (rank_rd)
   );

endmodule

// ===== tb/sv/lru_key_value_cache_unit_tb.sv =====
`timescale 1ns / 1ps
module lru_key_value_cache_unit_tb;
   import lkvc_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam int KW    = KEY_WIDTH_DEF;
   localparam int VW    = VALUE_WIDTH_DEF;

   typedef struct packed {
      logic               hit;
      logic [VW-1:0]      read_value;
      logic [COUNT_W-1:0] entry_count;
   } lookup_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_operation;
   logic [KW-1:0]       req_key;
   logic [VW-1:0]       req_write_value;
   logic                rsp_valid;
   logic                rsp_hit;
   logic [VW-1:0]       rsp_read_value;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                csr_write_enable;
   logic [CAP_W-1:0]    csr_write_data;

   // shadow copy of the cache contents
   logic [KW-1:0]       shadow_key[DEPTH];
   logic [VW-1:0]       shadow_value[DEPTH];
   logic                shadow_valid[DEPTH];
   logic [3:0]          shadow_rank[DEPTH];
   logic [COUNT_W-1:0]  shadow_count = '0;
   logic [CAP_W-1:0]    shadow_capacity = CAP_RESET;

   lookup_result_type   lookup_results_q[$];
   int                  mismatch_count = 0;
   bit                  idling_on = 1'b1;

   lru_key_value_cache_unit #(
      .DEPTH       (DEPTH),
      .KEY_WIDTH   (KW),
      .VALUE_WIDTH (VW)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_entry_count  (rsp_entry_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i]  = '0;
      end
   end

   function automatic int usable_capacity();
      if (shadow_capacity == 0)
         return 1;
      if (shadow_capacity > DEPTH)
         return DEPTH;
      return shadow_capacity;
   endfunction

   // applies one get/put to the shadow cache and returns what the response must be
   function automatic lookup_result_type lru_access(input logic op, input logic [KW-1:0] key,
                                                    input logic [VW-1:0] wval);
      lookup_result_type res;
      int                found;
      int                slot;
      logic [3:0]        old_rank;
      found = -1;
      slot = -1;
      res = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (found < 0 && shadow_valid[i] && shadow_key[i] == key)
            found = i;
      end
      if (found >= 0) begin
         if (op == OP_PUT)
            shadow_value[found] = wval;
         else
            res.read_value = shadow_value[found];
         // entries newer than this one age by one
         old_rank = shadow_rank[found];
         for (int i = 0; i < DEPTH; i++) begin
            if (shadow_valid[i] && shadow_rank[i] < old_rank)
               shadow_rank[i] = shadow_rank[i] + 1'b1;
         end
         shadow_rank[found] = '0;
      end else if (op == OP_PUT) begin
         if (shadow_count >= usable_capacity()) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot]))
                  slot = i;
            end
            if (slot >= 0) begin
               shadow_valid[slot] = 1'b0;
               shadow_count = shadow_count - 1'b1;
            end
         end
         if (slot < 0) begin
            for (int i = DEPTH - 1; i >= 0; i--) begin
               if (!shadow_valid[i])
                  slot = i;
            end
         end
         if (slot >= 0) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_valid[i])
                  shadow_rank[i] = shadow_rank[i] + 1'b1;
            end
            shadow_key[slot]   = key;
            shadow_value[slot] = wval;
            shadow_valid[slot] = 1'b1;
            shadow_rank[slot]  = '0;
            shadow_count = shadow_count + 1'b1;
         end
      end
      res.hit = (found >= 0);
      res.entry_count = shadow_count;
      return res;
   endfunction

   task automatic flag_field(input string name, input logic [VW-1:0] want,
                             input logic [VW-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_responses
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (lookup_results_q.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none actual hit=%b",
                     $time, rsp_hit);
            mismatch_count++;
         end else begin
            want = lookup_results_q.pop_front();
            flag_field("hit", VW'(want.hit), VW'(rsp_hit));
            flag_field("read_value", want.read_value, rsp_read_value);
            flag_field("entry_count", VW'(want.entry_count), VW'(rsp_entry_count));
         end
      end
   end

   // leaves start high on return; the caller either sends again or pauses
   task automatic send_request(input logic op, input logic [KW-1:0] key,
                               input logic [VW-1:0] wval);
      start           <= 1'b1;
      req_operation   <= op;
      req_key         <= key;
      req_write_value <= wval;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      lookup_results_q.push_back(lru_access(op, key, wval));
   endtask

   task automatic pause_requests();
      start <= 1'b0;
      // sometimes let the current request finish so the gap lands in the idle window
      if ($urandom_range(0, 1)) begin
         @(posedge clock);
         while (busy)
            @(posedge clock);
      end
      repeat ($urandom_range(1, 6))
         @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (idling_on && $urandom_range(0, 3) == 0)
         pause_requests();
   endtask

   task automatic wait_until_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (lookup_results_q.size() != 0 || busy)
         @(posedge clock);
      repeat (2)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_until_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      shadow_capacity = cap;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_basic_ops();
      send_request(OP_GET, '0, '1);
      send_request(OP_PUT, '0, '1);
      maybe_pause();
      send_request(OP_PUT, '1, '0);
      send_request(OP_GET, '0, '0);
      send_request(OP_GET, '1, 32'hDEAD_BEEF);
      maybe_pause();
      send_request(OP_PUT, '0, 32'h5A5A_5A5A);
      send_request(OP_GET, '0, '0);
   endtask

   task automatic test_eviction();
      write_capacity(5'd3);
      send_request(OP_PUT, 32'd1, 32'h1111_1111);
      send_request(OP_PUT, 32'd2, 32'h2222_2222);
      send_request(OP_GET, '1, '0);
      send_request(OP_GET, '0, '0);
      maybe_pause();
      send_request(OP_PUT, 32'd3, 32'h3333_3333);
      send_request(OP_GET, 32'd1, '0);
      send_request(OP_GET, 32'd2, '0);
   endtask

   task automatic test_capacity_limits();
      // zero acts as one; a count above the limit does not shrink, a put that misses evicts instead
      write_capacity(5'd0);
      send_request(OP_PUT, 32'd4, 32'h4444_4444);
      send_request(OP_GET, 32'd4, '0);
      // above the slot count acts as the slot count
      write_capacity(5'd31);
      send_request(OP_PUT, 32'd5, 32'h5555_5555);
      send_request(OP_PUT, 32'd6, 32'h6666_6666);
      write_capacity(5'd1);
      send_request(OP_PUT, 32'd7, 32'h7777_7777);
      send_request(OP_GET, 32'd7, '0);
      send_request(OP_PUT, 32'd3, '1);
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] cap_list[10] = '{5'd16, 5'd1, 5'd5, 5'd17, 5'd8,
                                         5'd31, 5'd2, 5'd0, 5'd12, 5'd16};
      logic [KW-1:0]    key_pool[24];
      int               pool_n;
      logic             op;
      logic [KW-1:0]    key;
      logic [VW-1:0]    wval;
      for (int i = 0; i < 24; i++)
         key_pool[i] = $urandom();
      for (int p = 0; p < 10; p++) begin
         write_capacity(cap_list[p]);
         idling_on = (p < 9);
         pool_n = (usable_capacity() >= DEPTH) ? 24 : $urandom_range(2, usable_capacity() + 4);
         // keep part of the old keys so earlier entries can still hit
         for (int i = 0; i < pool_n; i++) begin
            if ($urandom_range(0, 2) == 0)
               key_pool[i] = $urandom();
         end
         for (int n = 0; n < 93; n++) begin
            op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
            if ($urandom_range(0, 3) != 0)
               key = key_pool[$urandom_range(0, pool_n - 1)];
            else
               key = $urandom();
            case ($urandom_range(0, 9))
               0: wval = '0;
               1: wval = '1;
               default: wval = $urandom();
            endcase
            send_request(op, key, wval);
            maybe_pause();
         end
      end
   endtask

   initial begin
      int wait_cycles;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_operation    <= OP_GET;
      req_key          <= '0;
      req_write_value  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (5)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_eviction();
      test_capacity_limits();
      test_random_traffic();

      start <= 1'b0;
      wait_cycles = 0;
      while (lookup_results_q.size() != 0 && wait_cycles < 400) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * DEPTH + 8)
         @(posedge clock);
      if (lookup_results_q.size() != 0) begin
         $display("%0t: responses missing, expected %0d more actual 0", $time,
                  lookup_results_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("PASS lru_key_value_cache_unit");
      else
         $display("FAIL lru_key_value_cache_unit");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL lru_key_value_cache_unit");
      $finish;
   end

endmodule
